// ----- rtl/nfh_pkg.sv -----
`default_nettype none
package nfh_pkg;

  // Heap size in 8-byte units
  localparam int HEAP_UNITS_DEF = 4096;
  // Width of a request's unit count: 1 + ceil(65535 / 8) needs 14 bits
  localparam int NEED_W = 14;
  localparam logic [31:0] HEAP_BASE_RST = 32'h0001_0000;

  // Request codes
  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_FREE    = 3'd1;
  localparam logic [2:0] REQ_REALLOC = 3'd2;
  localparam logic [2:0] REQ_SIZE    = 3'd3;
  localparam logic [2:0] REQ_OWN     = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOT_OURS = 2'd1;
  localparam logic [1:0] STAT_OOM      = 2'd2;

  // Ownership answers
  localparam logic signed [1:0] OWN_NULL    = -2'sd1;
  localparam logic signed [1:0] OWN_OUTSIDE = 2'sd0;
  localparam logic signed [1:0] OWN_INSIDE  = 2'sd1;

endpackage
`default_nettype wire

// ----- rtl/nfh_if.sv -----
`default_nettype none
// Request channel
interface nfh_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] address;
  logic [15:0] size_bytes;

  modport source (output valid, req_type, address, size_bytes, input ready);
  modport sink   (input valid, req_type, address, size_bytes, output ready);
endinterface

// Result channel
interface nfh_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        result_address;
  logic [15:0]        result_size;
  logic signed [1:0]  ownership;
  logic [1:0]         status;
  logic [31:0]        copy_source;
  logic [31:0]        copy_dest;
  logic [15:0]        copy_bytes;
  logic [16:0]        bytes_allocated;
  logic [16:0]        high_water;

  modport source (output valid, result_address, result_size, ownership, status,
                  copy_source, copy_dest, copy_bytes, bytes_allocated, high_water,
                  input ready);
  modport sink   (input valid, result_address, result_size, ownership, status,
                  copy_source, copy_dest, copy_bytes, bytes_allocated, high_water,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/next_fit_free_list_heap_allocator.sv -----
`default_nettype none
// Run time grows with each free-list node visited, plus the header writes that end the item.
// A move (realloc) runs one alloc walk and one free walk, after a grow walk if growing in place was tried.
// Throughput: one item at a time; the free-list walk through the single-port header
// memory sets the rate.
// Reset (rst_n low, synchronous): one free block covers the whole heap, totals zero,
// heap_base 0x10000; no clearing pass is needed.
module next_fit_free_list_heap_allocator
  import nfh_pkg::*;
#(
  parameter int HEAP_UNITS = HEAP_UNITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  nfh_req_if.sink     in_chan,
  nfh_rsp_if.source   out_chan,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata
);

  localparam int UW = $clog2(HEAP_UNITS + 1);
  localparam int AW = $clog2(HEAP_UNITS);
  localparam int CW = ((UW > NEED_W) ? UW : NEED_W) + 1;
  localparam int TW = UW + 3;
  localparam logic [UW-1:0] SENT  = UW'(HEAP_UNITS);
  localparam logic [UW:0]   LAST  = (UW+1)'(HEAP_UNITS + 1);
  localparam logic [32:0]   SPAN  = 33'(HEAP_UNITS * 8);

  typedef struct packed {
    logic [UW-1:0] link;
    logic [UW-1:0] size;
  } hdr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_RES_RD, S_RES_CHK,
    S_AL_RD0, S_AL_INIT, S_AL_RD, S_AL_CHK, S_AL_WL, S_AL_W1, S_AL_W2, S_AL_FIN,
    S_AL_RET,
    S_FR_RD, S_FR_CHK, S_FR_RDN, S_FR_OVL, S_FR_WP, S_FR_WQ, S_FR_RET,
    S_RA, S_RA_SHW1, S_RA_SHW2,
    S_GR_RD0, S_GR_INIT, S_GR_RD, S_GR_CHK, S_GR_WQP, S_GR_WP, S_GR_WT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {RET_PLAIN, RET_SHRINK, RET_GROW, RET_MOVE} ret_t;
  typedef enum logic {AM_PLAIN, AM_MOVE} amode_t;

  state_t            state_r;
  ret_t              ret_r;
  amode_t            amode_r;
  logic [2:0]        req_r;
  logic [31:0]       addr_r;
  logic [15:0]       cb_r;
  logic [NEED_W-1:0] n_r;
  logic [UW-1:0]     h_r, hs_r, hnext_r;
  logic [UW-1:0]     q_r, qsz_r, p_r, nq_r, t_r, u_r, qs_r;
  logic [UW-1:0]     fp_r, fs_r, fpn_r, fpsz_r;
  logic              mrg_r, ok_r;
  logic [UW:0]       i_r;
  logic [TW-1:0]     total_r, peak_r, save_r;
  logic [UW-1:0]     sent_next_r, rover_r;
  logic              e0_r, rd_sent_r, rd_e0_r;
  logic [31:0]       base_r;
  hdr_t              mem_q;

  // result staging
  logic [31:0]       r_addr_r, r_csrc_r, r_cdst_r;
  logic [15:0]       r_size_r, r_cbytes_r;
  logic signed [1:0] r_own_r;
  logic [1:0]        r_stat_r;

  // output register
  logic              ov_r;
  logic [31:0]       o_addr_r, o_csrc_r, o_cdst_r;
  logic [15:0]       o_size_r, o_cbytes_r;
  logic signed [1:0] o_own_r;
  logic [1:0]        o_stat_r;
  logic [16:0]       o_total_r, o_peak_r;

  // header memory port
  hdr_t              mem [HEAP_UNITS];
  logic [UW-1:0]     mem_ix;
  logic              mem_we;
  hdr_t              mem_wd;
  hdr_t              hdr;

  function automatic logic [CW-1:0] cx(input logic [UW-1:0] v);
    return CW'(v);
  endfunction

  function automatic logic [UW-1:0] key(input logic [UW-1:0] v);
    return (v == SENT) ? '0 : v + UW'(1);
  endfunction

  function automatic logic [TW-1:0] bytes_of(input logic [UW-1:0] v);
    return TW'({v, 3'b000});
  endfunction

  logic [31:0] ua_h, ua_u;
  assign ua_h = base_r + ((32'(h_r) + 32'd1) << 3);
  assign ua_u = base_r + ((32'(u_r) + 32'd1) << 3);

  // pointer decode
  logic [32:0]       adiff;
  logic              a_in;
  logic [AW-1:0]     a_unit;
  assign adiff  = {1'b0, addr_r} - {1'b0, base_r};
  assign a_in   = !adiff[32] && (adiff < SPAN);
  assign a_unit = adiff[AW+2:3];

  // header view: sentinel and the reset image of unit 0 overlay the memory
  always_comb begin
    if (rd_sent_r)    hdr = '{link: sent_next_r, size: '0};
    else if (rd_e0_r) hdr = '{link: SENT, size: SENT};
    else              hdr = mem_q;
  end

  // shared comparisons
  logic [UW-1:0]     kp, kq, kn;
  logic              fr_found, ovl1, ovl2, tpn;
  logic [CW-1:0]     extra, nx;
  assign kp = key(fp_r);
  assign kq = key(q_r);
  assign kn = key(hdr.link);
  assign fr_found = (kp > kq && kp < kn) || (kq >= kn && (kp > kq || kp < kn));
  assign ovl1 = (q_r != SENT) && (kq < kp) && (cx(q_r) + cx(qsz_r) > cx(fp_r));
  assign ovl2 = (nq_r != SENT) && (key(nq_r) > kp) && (cx(fp_r) + cx(fs_r) > cx(nq_r));
  assign tpn  = (nq_r != SENT) && (cx(fp_r) + cx(fs_r) == cx(nq_r));
  assign extra = CW'(n_r) - cx(hs_r);
  assign nx    = cx(h_r) + cx(hs_r);

  logic [UW-1:0] h_plus_n;
  assign h_plus_n = UW'(cx(h_r) + CW'(n_r));

  // memory address and write data per state
  always_comb begin
    mem_ix = '0;
    mem_we = 1'b0;
    mem_wd = '0;
    case (state_r)
      S_RES_RD:  mem_ix = UW'(a_unit) - UW'(1);
      S_AL_RD0,
      S_GR_RD0:  mem_ix = rover_r;
      S_AL_RD,
      S_GR_RD:   mem_ix = p_r;
      S_FR_RD:   mem_ix = q_r;
      S_FR_RDN:  mem_ix = nq_r;
      S_AL_WL, S_GR_WQP: begin
        mem_ix = q_r; mem_we = 1'b1; mem_wd = '{link: nq_r, size: qsz_r};
      end
      S_AL_W1: begin
        mem_ix = p_r; mem_we = 1'b1; mem_wd = '{link: nq_r, size: t_r};
      end
      S_AL_W2: begin
        mem_ix = u_r; mem_we = 1'b1; mem_wd = '{link: '0, size: UW'(n_r)};
      end
      S_FR_WP: begin
        mem_ix = fp_r; mem_we = 1'b1; mem_wd = '{link: fpn_r, size: fpsz_r};
      end
      S_FR_WQ: begin
        mem_ix = q_r; mem_we = 1'b1;
        mem_wd = mrg_r ? '{link: fpn_r, size: qsz_r + fpsz_r} : '{link: fp_r, size: qsz_r};
      end
      S_RA_SHW1: begin
        mem_ix = h_plus_n; mem_we = 1'b1; mem_wd = '{link: '0, size: hs_r - UW'(n_r)};
      end
      S_RA_SHW2, S_GR_WP: begin
        mem_ix = h_r; mem_we = 1'b1; mem_wd = '{link: hnext_r, size: UW'(n_r)};
      end
      S_GR_WT: begin
        mem_ix = h_plus_n; mem_we = 1'b1;
        mem_wd = '{link: '0, size: UW'(cx(qs_r) - extra)};
      end
      default: ;
    endcase
  end

  // header memory
  always_ff @(posedge clk) begin
    if (mem_we && mem_ix != SENT) mem[mem_ix[AW-1:0]] <= mem_wd;
    if (!mem_we && mem_ix != SENT) mem_q <= mem[mem_ix[AW-1:0]];
  end

  assign in_chan.ready = (state_r == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sent_next_r <= '0;
      rover_r     <= SENT;
      total_r     <= '0;
      peak_r      <= '0;
      e0_r        <= 1'b1;
      rd_sent_r   <= 1'b0;
      rd_e0_r     <= 1'b0;
      base_r      <= HEAP_BASE_RST;
      ov_r        <= 1'b0;
    end else begin
      if (cfg_we) base_r <= cfg_wdata & 32'hFFFF_FFF8;
      if (ov_r && out_chan.ready) ov_r <= 1'b0;

      // track what the memory port returns next cycle
      rd_sent_r <= !mem_we && mem_ix == SENT;
      rd_e0_r   <= !mem_we && mem_ix == '0 && e0_r;
      if (mem_we && mem_ix == SENT) sent_next_r <= mem_wd.link;
      if (mem_we && mem_ix == '0) e0_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            req_r      <= in_chan.req_type;
            addr_r     <= in_chan.address;
            cb_r       <= in_chan.size_bytes;
            n_r        <= NEED_W'(1) + NEED_W'((17'(in_chan.size_bytes) + 17'd7) >> 3);
            r_addr_r   <= '0;
            r_size_r   <= '0;
            r_own_r    <= OWN_OUTSIDE;
            r_stat_r   <= STAT_OK;
            r_csrc_r   <= '0;
            r_cdst_r   <= '0;
            r_cbytes_r <= '0;
            state_r    <= S_DEC;
          end
        end

        // decode the request and the pointer
        S_DEC: begin
          h_r   <= UW'(a_unit) - UW'(1);
          amode_r <= AM_PLAIN;
          case (req_r)
            REQ_ALLOC: state_r <= S_AL_RD0;
            REQ_FREE, REQ_SIZE, REQ_REALLOC: begin
              if (req_r == REQ_REALLOC && addr_r == '0) begin
                state_r <= S_AL_RD0;
              end else if (addr_r == '0 || !a_in || a_unit == '0) begin
                if (req_r == REQ_SIZE) r_size_r <= 16'hFFFF;
                r_stat_r <= STAT_NOT_OURS;
                state_r  <= S_DONE;
              end else begin
                state_r <= S_RES_RD;
              end
            end
            REQ_OWN: begin
              r_own_r <= (addr_r == '0) ? OWN_NULL : (a_in ? OWN_INSIDE : OWN_OUTSIDE);
              state_r <= S_DONE;
            end
            default: begin
              r_stat_r <= STAT_NOT_OURS;
              state_r  <= S_DONE;
            end
          endcase
        end

        S_RES_RD: state_r <= S_RES_CHK;

        // check the header under the pointer
        S_RES_CHK: begin
          hs_r    <= hdr.size;
          hnext_r <= hdr.link;
          if (hdr.size == '0 || cx(h_r) + cx(hdr.size) > cx(SENT)) begin
            if (req_r == REQ_SIZE) r_size_r <= 16'hFFFF;
            r_stat_r <= STAT_NOT_OURS;
            state_r  <= S_DONE;
          end else if (req_r == REQ_SIZE) begin
            r_size_r <= 16'({hdr.size - UW'(1), 3'b000});
            state_r  <= S_DONE;
          end else if (req_r == REQ_FREE || cb_r == '0) begin
            fp_r    <= h_r;
            fs_r    <= hdr.size;
            q_r     <= rover_r;
            i_r     <= '0;
            ret_r   <= RET_PLAIN;
            state_r <= S_FR_RD;
          end else begin
            state_r <= S_RA;
          end
        end

        // alloc: next-fit walk from the rover
        S_AL_RD0: state_r <= S_AL_INIT;
        S_AL_INIT, S_GR_INIT: begin
          q_r     <= rover_r;
          qsz_r   <= hdr.size;
          p_r     <= hdr.link;
          i_r     <= '0;
          state_r <= (state_r == S_AL_INIT) ? S_AL_RD : S_GR_RD;
        end
        S_AL_RD: state_r <= S_AL_CHK;
        S_AL_CHK: begin
          if (p_r != SENT && cx(hdr.size) >= CW'(n_r)) begin
            nq_r <= hdr.link;
            t_r  <= hdr.size - UW'(n_r);
            if (cx(hdr.size) == CW'(n_r)) begin
              u_r     <= p_r;
              state_r <= S_AL_WL;
            end else begin
              u_r     <= p_r + hdr.size - UW'(n_r);
              state_r <= S_AL_W1;
            end
          end else if (p_r == rover_r || i_r == LAST) begin
            ok_r    <= 1'b0;
            state_r <= S_AL_RET;
          end else begin
            q_r     <= p_r;
            qsz_r   <= hdr.size;
            p_r     <= hdr.link;
            i_r     <= i_r + 1'b1;
            state_r <= S_AL_RD;
          end
        end
        S_AL_WL: state_r <= S_AL_FIN;
        S_AL_W1: state_r <= S_AL_W2;
        S_AL_W2: state_r <= S_AL_FIN;
        S_AL_FIN: begin
          rover_r <= q_r;
          total_r <= total_r + bytes_of(UW'(n_r));
          if (total_r + bytes_of(UW'(n_r)) > peak_r) peak_r <= total_r + bytes_of(UW'(n_r));
          ok_r    <= 1'b1;
          state_r <= S_AL_RET;
        end
        S_AL_RET: begin
          if (!ok_r) begin
            r_stat_r <= STAT_OOM;
            state_r  <= S_DONE;
          end else if (amode_r == AM_PLAIN) begin
            r_addr_r <= ua_u;
            state_r  <= S_DONE;
          end else begin
            // move: report the copy, then release the old block
            r_addr_r   <= ua_u;
            r_csrc_r   <= ua_h;
            r_cdst_r   <= ua_u;
            r_cbytes_r <= 16'({hs_r - UW'(1), 3'b000});
            fp_r       <= h_r;
            fs_r       <= hs_r;
            q_r        <= rover_r;
            i_r        <= '0;
            ret_r      <= RET_MOVE;
            state_r    <= S_FR_RD;
          end
        end

        // free: find the gap in address order
        S_FR_RD: state_r <= S_FR_CHK;
        S_FR_CHK: begin
          qsz_r <= hdr.size;
          nq_r  <= hdr.link;
          if (fr_found) begin
            state_r <= S_FR_RDN;
          end else if (i_r == LAST) begin
            ok_r    <= 1'b0;
            state_r <= S_FR_RET;
          end else begin
            q_r     <= hdr.link;
            i_r     <= i_r + 1'b1;
            state_r <= S_FR_RD;
          end
        end
        S_FR_RDN: state_r <= S_FR_OVL;
        S_FR_OVL: begin
          if (ovl1 || ovl2) begin
            ok_r    <= 1'b0;
            state_r <= S_FR_RET;
          end else begin
            fpsz_r  <= tpn ? fs_r + hdr.size : fs_r;
            fpn_r   <= tpn ? hdr.link : nq_r;
            mrg_r   <= (q_r != SENT) && (cx(q_r) + cx(qsz_r) == cx(fp_r));
            state_r <= S_FR_WP;
          end
        end
        S_FR_WP: state_r <= S_FR_WQ;
        S_FR_WQ: begin
          rover_r <= q_r;
          total_r <= (total_r >= bytes_of(fs_r)) ? total_r - bytes_of(fs_r) : '0;
          ok_r    <= 1'b1;
          state_r <= S_FR_RET;
        end
        S_FR_RET: begin
          state_r <= S_DONE;
          case (ret_r)
            RET_PLAIN:  r_stat_r <= ok_r ? STAT_OK : STAT_NOT_OURS;
            RET_SHRINK: r_addr_r <= ua_h;
            RET_GROW: begin
              r_addr_r <= ua_h;
              if (total_r > peak_r) peak_r <= total_r;
            end
            RET_MOVE:   peak_r <= (save_r > total_r) ? save_r : total_r;
            default: ;
          endcase
        end

        // realloc: keep, shrink, grow or move
        S_RA: begin
          if (CW'(n_r) == cx(hs_r)) begin
            r_addr_r <= ua_h;
            state_r  <= S_DONE;
          end else if (CW'(n_r) < cx(hs_r)) begin
            state_r <= S_RA_SHW1;
          end else if (nx < cx(SENT)) begin
            state_r <= S_GR_RD0;
          end else begin
            save_r  <= peak_r;
            amode_r <= AM_MOVE;
            state_r <= S_AL_RD0;
          end
        end
        S_RA_SHW1: state_r <= S_RA_SHW2;
        S_RA_SHW2: begin
          fp_r    <= h_plus_n;
          fs_r    <= hs_r - UW'(n_r);
          q_r     <= rover_r;
          i_r     <= '0;
          ret_r   <= RET_SHRINK;
          state_r <= S_FR_RD;
        end

        // grow: look for the free block right after this one
        S_GR_RD0: state_r <= S_GR_INIT;
        S_GR_RD:  state_r <= S_GR_CHK;
        S_GR_CHK: begin
          if (cx(p_r) == nx) begin
            if (cx(hdr.size) < extra) begin
              save_r  <= peak_r;
              amode_r <= AM_MOVE;
              state_r <= S_AL_RD0;
            end else begin
              nq_r    <= hdr.link;
              qs_r    <= hdr.size;
              state_r <= S_GR_WQP;
            end
          end else if (p_r == rover_r || i_r == LAST) begin
            save_r  <= peak_r;
            amode_r <= AM_MOVE;
            state_r <= S_AL_RD0;
          end else begin
            q_r     <= p_r;
            qsz_r   <= hdr.size;
            p_r     <= hdr.link;
            i_r     <= i_r + 1'b1;
            state_r <= S_GR_RD;
          end
        end
        S_GR_WQP: begin
          total_r <= total_r + bytes_of(qs_r);
          state_r <= S_GR_WP;
        end
        S_GR_WP: begin
          if (cx(qs_r) == extra) begin
            rover_r  <= nq_r;
            if (total_r > peak_r) peak_r <= total_r;
            r_addr_r <= ua_h;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_GR_WT;
          end
        end
        S_GR_WT: begin
          rover_r <= q_r;
          fp_r    <= h_plus_n;
          fs_r    <= UW'(cx(qs_r) - extra);
          i_r     <= '0;
          ret_r   <= RET_GROW;
          state_r <= S_FR_RD;
        end

        // hand the result to the output register
        S_DONE: begin
          if (!ov_r || out_chan.ready) begin
            ov_r       <= 1'b1;
            o_addr_r   <= r_addr_r;
            o_size_r   <= r_size_r;
            o_own_r    <= r_own_r;
            o_stat_r   <= r_stat_r;
            o_csrc_r   <= r_csrc_r;
            o_cdst_r   <= r_cdst_r;
            o_cbytes_r <= r_cbytes_r;
            o_total_r  <= 17'(total_r);
            o_peak_r   <= 17'(peak_r);
            state_r    <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid           = ov_r;
  assign out_chan.result_address  = o_addr_r;
  assign out_chan.result_size     = o_size_r;
  assign out_chan.ownership       = o_own_r;
  assign out_chan.status          = o_stat_r;
  assign out_chan.copy_source     = o_csrc_r;
  assign out_chan.copy_dest       = o_cdst_r;
  assign out_chan.copy_bytes      = o_cbytes_r;
  assign out_chan.bytes_allocated = o_total_r;
  assign out_chan.high_water      = o_peak_r;

endmodule
`default_nettype wire

// ----- rtl/nfh_checker.sv -----
`default_nettype none
module nfh_checker
  import nfh_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_status,
  input wire [31:0] out_result_address,
  input wire [16:0] out_bytes_allocated,
  input wire [16:0] out_high_water
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_address))
    else $error("result changed while stalled");

  // the peak never trails the running total
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_high_water >= out_bytes_allocated)
    else $error("high water below bytes allocated");

  // a failed request returns a null pointer
  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_result_address == '0)
    else $error("failure with non-null address");

  // an accepted item keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

endmodule

bind next_fit_free_list_heap_allocator nfh_checker u_nfh_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_status          (out_chan.status),
  .out_result_address  (out_chan.result_address),
  .out_bytes_allocated (out_chan.bytes_allocated),
  .out_high_water      (out_chan.high_water)
);
`default_nettype wire
